// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define SCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/scm_pkg.sv -----
// shared constants, codes and types of the stick calibrate and map unit
`default_nettype none
package scm_pkg;

   localparam int NUM_CHANNELS = 6;
   localparam int NUM_STICKS = 4;
   localparam int SAMPLE_BITS = 12;

   localparam int CH_IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CH_FIELD_BITS = 3;
   localparam int CH_CMP_BITS = 5;
   localparam int MODE_BITS = 3;
   localparam int STROKE_BITS = 12;
   localparam int WORD_BITS = 16;
   localparam int RANGE_BITS = SAMPLE_BITS + 1;
   localparam int SPAN_BITS = RANGE_BITS + 1;
   localparam int GAIN_BITS = 25;
   localparam int GAIN_FRAC = 16;
   localparam int DIVIDEND_BITS = STROKE_BITS + GAIN_FRAC;
   localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);
   localparam int PROD_BITS = RANGE_BITS + GAIN_BITS;
   localparam int CONV_SUM_BITS = PROD_BITS - GAIN_FRAC + 1;

   localparam int BAT_BITS = 13;
   localparam int BAT_SCALE_BITS = 13;
   localparam int BAT_MV_PROD_BITS = SAMPLE_BITS + BAT_SCALE_BITS;
   localparam int BAT_SUM_BITS = BAT_BITS + 4;
   localparam int RECIP_BITS = 16;
   localparam int RECIP_SHIFT = 19;
   localparam int BAT_PROD_BITS = BAT_SUM_BITS + RECIP_BITS;

   localparam int REQ_TDATA_BITS = 16;
   localparam int REQ_TUSER_BITS = MODE_BITS;
   localparam int RSP_TDATA_BITS = 24;
   localparam int RSP_TUSER_BITS = 1;
   localparam int RSP_PAD_BITS = RSP_TDATA_BITS - WORD_BITS - CH_FIELD_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = WORD_BITS;

   localparam logic [RANGE_BITS-1:0] FULL_SCALE = RANGE_BITS'(1 << SAMPLE_BITS);
   localparam logic [RANGE_BITS-1:0] SAMPLE_MAX = RANGE_BITS'((1 << SAMPLE_BITS) - 1);
   localparam logic [SAMPLE_BITS-1:0] HALF_MINUS_ONE =
      SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(2048);
   localparam logic [SAMPLE_BITS-1:0] CAL_CENTER = SAMPLE_BITS'(1000);
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = {GAIN_BITS{1'b1}};
   localparam logic [GAIN_BITS-1:0] GAIN_HIGH_RESET = GAIN_BITS'(16000);
   localparam logic [BAT_BITS-1:0] BAT_RESET = BAT_BITS'(4200);
   localparam logic [BAT_SCALE_BITS-1:0] BAT_SCALE = BAT_SCALE_BITS'(6600);
   localparam logic [RECIP_BITS-1:0] RECIP_TEN = RECIP_BITS'(52429);

   localparam logic [STROKE_BITS-1:0] STROKE_RESET = STROKE_BITS'(500);
   localparam logic [WORD_BITS-1:0] LOW_BASE_RESET = WORD_BITS'(1000);
   localparam logic [WORD_BITS-1:0] MID_BASE_RESET = WORD_BITS'(1500);
   localparam logic [WORD_BITS-1:0] DEAD_LOW_RESET = WORD_BITS'(1480);
   localparam logic [WORD_BITS-1:0] DEAD_HIGH_RESET = WORD_BITS'(1520);
   localparam logic [WORD_BITS-1:0] CENTER_VALUE_RESET = WORD_BITS'(1500);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STROKE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_BASE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MID_BASE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_LOW = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_HIGH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_VALUE = 3'd5;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_RESET_CAL = 3'd0,
      MODE_TRACK = 3'd1,
      MODE_CAPTURE = 3'd2,
      MODE_GAINS = 3'd3,
      MODE_CONVERT = 3'd4,
      MODE_BATTERY = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_HIGH,
      ST_DIV_LOW,
      ST_CONV_DIFF,
      ST_CONV_MUL,
      ST_CONV_ADD,
      ST_BAT_MUL,
      ST_BAT_SUM,
      ST_BAT_DIV,
      ST_BAT_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic clear_cal;
      logic track;
      logic capture;
      logic div_start;
      logic div_sel_low;
      logic gain_high_wr;
      logic gain_low_wr;
      logic conv_diff;
      logic conv_mul;
      logic conv_add;
      logic bat_mul;
      logic bat_sum;
      logic bat_div;
      logic bat_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic ch_ok;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ----- sv/scm_div.sv -----
// bit-serial restoring divider for the gain quotient
`default_nettype none
module scm_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [scm_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  wire logic [scm_pkg::RANGE_BITS-1:0]       divisor,
   output logic                                      done,
   output logic [scm_pkg::DIVIDEND_BITS-1:0]         quotient
);

   localparam int REM_BITS = scm_pkg::RANGE_BITS + 1;

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [scm_pkg::DIV_COUNT_BITS-1:0]   count_ff, count_in;
   logic [REM_BITS-1:0]                  rem_ff, rem_in;
   logic [scm_pkg::DIVIDEND_BITS-1:0]    quo_ff, quo_in;
   logic [scm_pkg::RANGE_BITS-1:0]       dsr_ff, dsr_in;
   logic [REM_BITS-1:0]                  shifted;

   assign shifted = {rem_ff[REM_BITS-2:0], quo_ff[scm_pkg::DIVIDEND_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = scm_pkg::DIV_COUNT_BITS'(scm_pkg::DIVIDEND_BITS);
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[scm_pkg::DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[scm_pkg::DIVIDEND_BITS-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == scm_pkg::DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- sv/scm_dp.sv -----
// datapath: calibration store, divider, multipliers and result register
`default_nettype none
module scm_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [scm_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  wire logic [scm_pkg::REQ_TUSER_BITS-1:0]   req_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [scm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [scm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire scm_pkg::cmd_type                     cmd,
   output scm_pkg::status_type                       status,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [scm_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   output logic [scm_pkg::RSP_TUSER_BITS-1:0]        rsp_tuser
);

   localparam int NC = scm_pkg::NUM_CHANNELS;
   localparam int RB = scm_pkg::RANGE_BITS;
   localparam int SB = scm_pkg::SAMPLE_BITS;
   localparam int GB = scm_pkg::GAIN_BITS;
   localparam int WB = scm_pkg::WORD_BITS;

   function automatic logic [GB-1:0] gain_of(
      input logic signed [scm_pkg::SPAN_BITS-1:0] span,
      input logic [scm_pkg::DIVIDEND_BITS-1:0] q
   );
      logic [GB-1:0] g;
      if (span[scm_pkg::SPAN_BITS-1] || span == '0) begin
         g = scm_pkg::GAIN_ONE;
      end else if (q[scm_pkg::DIVIDEND_BITS-1:GB] != '0) begin
         g = scm_pkg::GAIN_MAX;
      end else begin
         g = q[GB-1:0];
      end
      return g;
   endfunction

   // configuration
   logic [scm_pkg::STROKE_BITS-1:0] stroke_ff, stroke_in;
   logic [WB-1:0] low_base_ff, low_base_in, mid_base_ff, mid_base_in;
   logic [WB-1:0] dead_low_ff, dead_low_in, dead_high_ff, dead_high_in;
   logic [WB-1:0] center_value_ff, center_value_in;

   // current transaction
   scm_pkg::mode_type                  item_mode_ff, item_mode_in;
   logic [scm_pkg::CH_FIELD_BITS-1:0]  item_ch_ff, item_ch_in;
   logic [SB-1:0]                      item_sample_ff, item_sample_in;

   // calibration store
   logic [RB-1:0] range_min_ff [NC], range_min_in [NC];
   logic [RB-1:0] range_max_ff [NC], range_max_in [NC];
   logic [SB-1:0] center_ff [NC], center_in [NC];
   logic [GB-1:0] gain_high_ff [NC], gain_high_in [NC];
   logic [GB-1:0] gain_low_ff [NC], gain_low_in [NC];
   logic [scm_pkg::BAT_BITS-1:0] bat_avg_ff, bat_avg_in;

   // work registers
   logic [RB-1:0] diff_ff, diff_in;
   logic [GB-1:0] gsel_ff, gsel_in;
   logic [WB-1:0] base_ff, base_in;
   logic [scm_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [scm_pkg::BAT_BITS-1:0] mv_ff, mv_in;
   logic [scm_pkg::BAT_SUM_BITS-1:0] bsum_ff, bsum_in;
   logic [scm_pkg::BAT_PROD_BITS-1:0] bprod_ff, bprod_in;
   logic [WB-1:0] res_value_ff, res_value_in;
   logic res_kind_ff, res_kind_in;
   logic [scm_pkg::CH_FIELD_BITS-1:0] res_ch_ff, res_ch_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic [scm_pkg::CH_FIELD_BITS-1:0] rsp_ch_ff, rsp_ch_in;

   logic [scm_pkg::CH_IDX_BITS-1:0] ch_idx;
   logic ch_ok, stick;
   logic [RB-1:0] s_ext, c_ext, min_ext;
   logic signed [scm_pkg::SPAN_BITS-1:0] span_high, span_low;
   logic [RB-1:0] div_divisor;
   logic div_done;
   logic [scm_pkg::DIVIDEND_BITS-1:0] div_quotient;
   logic [scm_pkg::BAT_MV_PROD_BITS-1:0] mv_prod;
   logic [scm_pkg::CONV_SUM_BITS-1:0] conv_sum;
   logic [WB-1:0] conv_sat;
   logic rsp_free;

   assign ch_idx = scm_pkg::CH_IDX_BITS'(item_ch_ff);
   assign ch_ok = scm_pkg::CH_CMP_BITS'(item_ch_ff) < scm_pkg::CH_CMP_BITS'(NC);
   assign stick = scm_pkg::CH_CMP_BITS'(item_ch_ff) < scm_pkg::CH_CMP_BITS'(scm_pkg::NUM_STICKS);
   assign s_ext = {1'b0, item_sample_ff};
   assign c_ext = {1'b0, center_ff[ch_idx]};
   assign min_ext = range_min_ff[ch_idx];

   assign span_high = $signed({1'b0, range_max_ff[ch_idx]}) - $signed({2'b00, center_ff[ch_idx]});
   assign span_low = $signed({2'b00, center_ff[ch_idx]}) - $signed({1'b0, range_min_ff[ch_idx]});
   assign div_divisor = cmd.div_sel_low ? span_low[RB-1:0] : span_high[RB-1:0];

   scm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({stroke_ff, {scm_pkg::GAIN_FRAC{1'b0}}}),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign mv_prod = scm_pkg::BAT_MV_PROD_BITS'(item_sample_ff) *
                    scm_pkg::BAT_MV_PROD_BITS'(scm_pkg::BAT_SCALE);
   assign conv_sum = scm_pkg::CONV_SUM_BITS'(prod_ff[scm_pkg::PROD_BITS-1:scm_pkg::GAIN_FRAC]) +
                     scm_pkg::CONV_SUM_BITS'(base_ff);
   assign conv_sat = (conv_sum[scm_pkg::CONV_SUM_BITS-1:WB] != '0) ? {WB{1'b1}} : conv_sum[WB-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stroke_in = stroke_ff;
      low_base_in = low_base_ff;
      mid_base_in = mid_base_ff;
      dead_low_in = dead_low_ff;
      dead_high_in = dead_high_ff;
      center_value_in = center_value_ff;
      if (csr_we) begin
         case (csr_index)
            scm_pkg::CSR_STROKE: stroke_in = csr_wdata[scm_pkg::STROKE_BITS-1:0];
            scm_pkg::CSR_LOW_BASE: low_base_in = csr_wdata;
            scm_pkg::CSR_MID_BASE: mid_base_in = csr_wdata;
            scm_pkg::CSR_DEAD_LOW: dead_low_in = csr_wdata;
            scm_pkg::CSR_DEAD_HIGH: dead_high_in = csr_wdata;
            scm_pkg::CSR_CENTER_VALUE: center_value_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      item_mode_in = item_mode_ff;
      item_ch_in = item_ch_ff;
      item_sample_in = item_sample_ff;
      if (cmd.load_item) begin
         item_mode_in = scm_pkg::mode_type'(req_tuser);
         item_ch_in = req_tdata[scm_pkg::CH_FIELD_BITS-1:0];
         item_sample_in = req_tdata[scm_pkg::CH_FIELD_BITS +: SB];
      end
   end

   always_comb begin
      range_min_in = range_min_ff;
      range_max_in = range_max_ff;
      center_in = center_ff;
      gain_high_in = gain_high_ff;
      gain_low_in = gain_low_ff;
      if (cmd.clear_cal) begin
         for (int c = 0; c < NC; c++) begin
            range_min_in[c] = scm_pkg::FULL_SCALE;
            range_max_in[c] = '0;
            center_in[c] = scm_pkg::CAL_CENTER;
            gain_high_in[c] = scm_pkg::GAIN_ONE;
            gain_low_in[c] = scm_pkg::GAIN_ONE;
         end
      end
      if (cmd.track) begin
         if (stick) begin
            if (s_ext > range_max_ff[ch_idx]) range_max_in[ch_idx] = s_ext;
            if (s_ext < range_min_ff[ch_idx]) range_min_in[ch_idx] = s_ext;
         end else begin
            range_min_in[ch_idx] = '0;
            if (scm_pkg::SAMPLE_MAX > range_max_ff[ch_idx]) begin
               range_max_in[ch_idx] = scm_pkg::SAMPLE_MAX;
            end
         end
      end
      if (cmd.capture) begin
         center_in[ch_idx] = stick ? item_sample_ff : scm_pkg::HALF_MINUS_ONE;
      end
      if (cmd.gain_high_wr) gain_high_in[ch_idx] = gain_of(span_high, div_quotient);
      if (cmd.gain_low_wr) gain_low_in[ch_idx] = gain_of(span_low, div_quotient);
   end

   always_comb begin
      diff_in = diff_ff;
      gsel_in = gsel_ff;
      base_in = base_ff;
      prod_in = prod_ff;
      mv_in = mv_ff;
      bsum_in = bsum_ff;
      bprod_in = bprod_ff;
      bat_avg_in = bat_avg_ff;
      res_value_in = res_value_ff;
      res_kind_in = res_kind_ff;
      res_ch_in = res_ch_ff;
      if (cmd.conv_diff) begin
         if (item_sample_ff >= center_ff[ch_idx]) begin
            diff_in = s_ext - c_ext;
            gsel_in = gain_high_ff[ch_idx];
            base_in = mid_base_ff;
         end else begin
            diff_in = (s_ext >= min_ext) ? s_ext - min_ext : min_ext - s_ext;
            gsel_in = gain_low_ff[ch_idx];
            base_in = low_base_ff;
         end
      end
      if (cmd.conv_mul) begin
         prod_in = scm_pkg::PROD_BITS'(diff_ff) * scm_pkg::PROD_BITS'(gsel_ff);
      end
      if (cmd.conv_add) begin
         res_value_in = conv_sat;
         if (stick && conv_sat < dead_high_ff && conv_sat > dead_low_ff) begin
            res_value_in = center_value_ff;
         end
         res_kind_in = 1'b0;
         res_ch_in = item_ch_ff;
      end
      if (cmd.bat_mul) begin
         mv_in = mv_prod[SB +: scm_pkg::BAT_BITS];
      end
      if (cmd.bat_sum) begin
         bsum_in = scm_pkg::BAT_SUM_BITS'(mv_ff) +
                   (scm_pkg::BAT_SUM_BITS'(bat_avg_ff) << 3) +
                   scm_pkg::BAT_SUM_BITS'(bat_avg_ff);
      end
      if (cmd.bat_div) begin
         // divide by ten through the reciprocal
         bprod_in = scm_pkg::BAT_PROD_BITS'(bsum_ff) * scm_pkg::BAT_PROD_BITS'(scm_pkg::RECIP_TEN);
      end
      if (cmd.bat_wr) begin
         bat_avg_in = bprod_ff[scm_pkg::RECIP_SHIFT +: scm_pkg::BAT_BITS];
         res_value_in = WB'(bprod_ff[scm_pkg::RECIP_SHIFT +: scm_pkg::BAT_BITS]);
         res_kind_in = 1'b1;
         res_ch_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_ch_in = rsp_ch_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_kind_in = res_kind_ff;
         rsp_ch_in = res_ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_ff <= scm_pkg::STROKE_RESET;
         low_base_ff <= scm_pkg::LOW_BASE_RESET;
         mid_base_ff <= scm_pkg::MID_BASE_RESET;
         dead_low_ff <= scm_pkg::DEAD_LOW_RESET;
         dead_high_ff <= scm_pkg::DEAD_HIGH_RESET;
         center_value_ff <= scm_pkg::CENTER_VALUE_RESET;
         for (int c = 0; c < NC; c++) begin
            range_min_ff[c] <= scm_pkg::RANGE_RESET;
            range_max_ff[c] <= scm_pkg::RANGE_RESET;
            center_ff[c] <= '0;
            gain_high_ff[c] <= scm_pkg::GAIN_HIGH_RESET;
            gain_low_ff[c] <= '0;
         end
         bat_avg_ff <= scm_pkg::BAT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         stroke_ff <= stroke_in;
         low_base_ff <= low_base_in;
         mid_base_ff <= mid_base_in;
         dead_low_ff <= dead_low_in;
         dead_high_ff <= dead_high_in;
         center_value_ff <= center_value_in;
         range_min_ff <= range_min_in;
         range_max_ff <= range_max_in;
         center_ff <= center_in;
         gain_high_ff <= gain_high_in;
         gain_low_ff <= gain_low_in;
         bat_avg_ff <= bat_avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff <= item_mode_in;
      item_ch_ff <= item_ch_in;
      item_sample_ff <= item_sample_in;
      diff_ff <= diff_in;
      gsel_ff <= gsel_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      mv_ff <= mv_in;
      bsum_ff <= bsum_in;
      bprod_ff <= bprod_in;
      res_value_ff <= res_value_in;
      res_kind_ff <= res_kind_in;
      res_ch_ff <= res_ch_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ch_ff <= rsp_ch_in;
   end

   assign status.mode = item_mode_ff;
   assign status.ch_ok = ch_ok;
   assign status.div_done = div_done;
   assign status.rsp_free = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{scm_pkg::RSP_PAD_BITS{1'b0}}, rsp_ch_ff, rsp_value_ff};
   assign rsp_tuser = rsp_kind_ff;

endmodule
`default_nettype wire

// ----- sv/scm_ctrl.sv -----
// controller state machine sequencing each transaction through the datapath
`default_nettype none
module scm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire scm_pkg::status_type    status,
   output scm_pkg::cmd_type            cmd
);

   scm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scm_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = scm_pkg::ST_DECODE;
         end
         scm_pkg::ST_DECODE: begin
            case (status.mode)
               scm_pkg::MODE_GAINS: begin
                  state_in = status.ch_ok ? scm_pkg::ST_DIV_HIGH : scm_pkg::ST_IDLE;
               end
               scm_pkg::MODE_CONVERT: begin
                  state_in = status.ch_ok ? scm_pkg::ST_CONV_DIFF : scm_pkg::ST_IDLE;
               end
               scm_pkg::MODE_BATTERY: state_in = scm_pkg::ST_BAT_MUL;
               default: state_in = scm_pkg::ST_IDLE;
            endcase
         end
         scm_pkg::ST_DIV_HIGH: begin
            if (status.div_done) state_in = scm_pkg::ST_DIV_LOW;
         end
         scm_pkg::ST_DIV_LOW: begin
            if (status.div_done) state_in = scm_pkg::ST_IDLE;
         end
         scm_pkg::ST_CONV_DIFF: state_in = scm_pkg::ST_CONV_MUL;
         scm_pkg::ST_CONV_MUL: state_in = scm_pkg::ST_CONV_ADD;
         scm_pkg::ST_CONV_ADD: state_in = scm_pkg::ST_OUT;
         scm_pkg::ST_BAT_MUL: state_in = scm_pkg::ST_BAT_SUM;
         scm_pkg::ST_BAT_SUM: state_in = scm_pkg::ST_BAT_DIV;
         scm_pkg::ST_BAT_DIV: state_in = scm_pkg::ST_BAT_WR;
         scm_pkg::ST_BAT_WR: state_in = scm_pkg::ST_OUT;
         scm_pkg::ST_OUT: begin
            if (status.rsp_free) state_in = scm_pkg::ST_IDLE;
         end
         default: state_in = scm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         scm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_item = req_tvalid;
         end
         scm_pkg::ST_DECODE: begin
            case (status.mode)
               scm_pkg::MODE_RESET_CAL: cmd.clear_cal = 1'b1;
               scm_pkg::MODE_TRACK: cmd.track = status.ch_ok;
               scm_pkg::MODE_CAPTURE: cmd.capture = status.ch_ok;
               scm_pkg::MODE_GAINS: cmd.div_start = status.ch_ok;
               default: ;
            endcase
         end
         scm_pkg::ST_DIV_HIGH: begin
            if (status.div_done) begin
               cmd.gain_high_wr = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_low = 1'b1;
            end
         end
         scm_pkg::ST_DIV_LOW: cmd.gain_low_wr = status.div_done;
         scm_pkg::ST_CONV_DIFF: cmd.conv_diff = 1'b1;
         scm_pkg::ST_CONV_MUL: cmd.conv_mul = 1'b1;
         scm_pkg::ST_CONV_ADD: cmd.conv_add = 1'b1;
         scm_pkg::ST_BAT_MUL: cmd.bat_mul = 1'b1;
         scm_pkg::ST_BAT_SUM: cmd.bat_sum = 1'b1;
         scm_pkg::ST_BAT_DIV: cmd.bat_div = 1'b1;
         scm_pkg::ST_BAT_WR: cmd.bat_wr = 1'b1;
         scm_pkg::ST_OUT: cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/stick_calibrate_and_map_unit.sv -----
// top level of the stick calibrate and map unit
//
//   channel   direction  contents
//   req_      in         tdata: channel[2:0], sample[14:3]; tuser: mode[2:0]
//   rsp_      out        tdata: value[15:0], out_channel[18:16]; tuser: kind[0]
//   csr_      in         write enable, register index, 16-bit write data
//
// convert runs decode, diff, mul, add; battery decode, mul, sum, div, write
// compute gains makes two 28-step runs of the serial divider, high then low
// reset cal, track, capture and unused modes end after the decode state
// a waiting result does not block the next transaction until it needs the output
// reset is synchronous; it restores configuration and calibration state
`default_nettype none
module stick_calibrate_and_map_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // channel[2:0], sample[14:3]
   input  wire logic [scm_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // mode[2:0]
   input  wire logic [scm_pkg::REQ_TUSER_BITS-1:0]   req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // value[15:0], out_channel[18:16]
   output logic [scm_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   // kind[0]
   output logic [scm_pkg::RSP_TUSER_BITS-1:0]        rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [scm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [scm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   scm_pkg::cmd_type    cmd;
   scm_pkg::status_type status;

   scm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ----- sv/scm_checker.sv -----
// port-level checker bound to the stick calibrate and map unit
`include "assert_macros.svh"
`default_nettype none
module scm_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [scm_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  wire logic [scm_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser
);

   `SCM_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `SCM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp transaction changed")

   `SCM_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "req taken while busy")

   `SCM_ASSERT(a_battery_shape, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[18:13] == 6'd0, "battery result has channel or overrange bits")

endmodule

bind stick_calibrate_and_map_unit scm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- sim/stick_calibrate_and_map_unit_tb.sv -----
// self-checking testbench of the stick calibrate and map unit
module stick_calibrate_and_map_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 200;
   localparam logic [scm_pkg::MODE_BITS-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [scm_pkg::MODE_BITS-1:0] MODE_SPARE_B = 3'd7;

   typedef struct {
      logic [15:0] value;
      logic        kind;
      logic [2:0]  chan;
   } map_result_type;

   typedef struct {
      logic [scm_pkg::MODE_BITS-1:0]   mode;
      logic [2:0]                      chan;
      logic [scm_pkg::SAMPLE_BITS-1:0] sample;
      bit                              fixed;
      logic [15:0]                     want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire  req_tready;
   logic [scm_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [scm_pkg::REQ_TUSER_BITS-1:0] req_tuser = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire  [scm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   wire  [scm_pkg::RSP_TUSER_BITS-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [scm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [scm_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   int unsigned cycle_count = 0;
   int mismatches = 0;
   bit steady = 1'b0;
   map_result_type mapped_values [$];
   stim_row_type directed_rows [28];
   logic [15:0] next_cfg [6];

   // predictor copy of configuration and calibration state
   logic [scm_pkg::STROKE_BITS-1:0] cfg_stroke;
   logic [15:0] cfg_low_base, cfg_mid_base, cfg_dead_low, cfg_dead_high, cfg_center;
   logic [scm_pkg::RANGE_BITS-1:0] cal_min [scm_pkg::NUM_CHANNELS];
   logic [scm_pkg::RANGE_BITS-1:0] cal_max [scm_pkg::NUM_CHANNELS];
   logic [scm_pkg::SAMPLE_BITS-1:0] cal_mid [scm_pkg::NUM_CHANNELS];
   logic [scm_pkg::GAIN_BITS-1:0] slope_up [scm_pkg::NUM_CHANNELS];
   logic [scm_pkg::GAIN_BITS-1:0] slope_down [scm_pkg::NUM_CHANNELS];
   logic [scm_pkg::BAT_BITS-1:0] bat_avg;

   stick_calibrate_and_map_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 15);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   function automatic logic [scm_pkg::GAIN_BITS-1:0] slope_of(input int span);
      longint unsigned q;
      if (span <= 0)
         return scm_pkg::GAIN_ONE;
      q = (64'(cfg_stroke) << scm_pkg::GAIN_FRAC) / 64'(span);
      if (q > 64'(scm_pkg::GAIN_MAX))
         return scm_pkg::GAIN_MAX;
      return q[scm_pkg::GAIN_BITS-1:0];
   endfunction

   function automatic bit map_item(input logic [scm_pkg::MODE_BITS-1:0] mode,
                                   input logic [2:0] chan,
                                   input logic [scm_pkg::SAMPLE_BITS-1:0] sample,
                                   output map_result_type res);
      longint unsigned v;
      int unsigned diff;
      int unsigned mv;
      logic [scm_pkg::RANGE_BITS-1:0] lo, hi;
      bit stick;
      stick = chan < scm_pkg::NUM_STICKS;
      res.value = '0;
      res.kind = 1'b0;
      res.chan = '0;
      if (mode == scm_pkg::MODE_RESET_CAL) begin
         for (int c = 0; c < scm_pkg::NUM_CHANNELS; c++) begin
            cal_min[c] = scm_pkg::FULL_SCALE;
            cal_max[c] = '0;
            cal_mid[c] = scm_pkg::CAL_CENTER;
            slope_up[c] = scm_pkg::GAIN_ONE;
            slope_down[c] = scm_pkg::GAIN_ONE;
         end
         return 1'b0;
      end
      if (mode == scm_pkg::MODE_BATTERY) begin
         mv = (32'(sample) * 6600) / 4096;
         bat_avg = scm_pkg::BAT_BITS'((mv + 9 * 32'(bat_avg)) / 10);
         res.value = 16'(bat_avg);
         res.kind = 1'b1;
         return 1'b1;
      end
      if (chan >= scm_pkg::NUM_CHANNELS || mode > scm_pkg::MODE_BATTERY)
         return 1'b0;
      if (mode == scm_pkg::MODE_TRACK) begin
         if (stick) begin
            lo = scm_pkg::RANGE_BITS'(sample);
            hi = scm_pkg::RANGE_BITS'(sample);
         end else begin
            lo = '0;
            hi = scm_pkg::SAMPLE_MAX;
         end
         if (hi > cal_max[chan]) cal_max[chan] = hi;
         if (lo < cal_min[chan]) cal_min[chan] = lo;
         return 1'b0;
      end
      if (mode == scm_pkg::MODE_CAPTURE) begin
         cal_mid[chan] = stick ? sample : scm_pkg::HALF_MINUS_ONE;
         return 1'b0;
      end
      if (mode == scm_pkg::MODE_GAINS) begin
         slope_up[chan] = slope_of(int'(cal_max[chan]) - int'(cal_mid[chan]));
         slope_down[chan] = slope_of(int'(cal_mid[chan]) - int'(cal_min[chan]));
         return 1'b0;
      end
      // convert
      if (sample >= cal_mid[chan]) begin
         diff = 32'(sample) - 32'(cal_mid[chan]);
         v = ((64'(diff) * 64'(slope_up[chan])) >> scm_pkg::GAIN_FRAC) + 64'(cfg_mid_base);
      end else begin
         diff = (32'(sample) >= 32'(cal_min[chan])) ? 32'(sample) - 32'(cal_min[chan])
                                                   : 32'(cal_min[chan]) - 32'(sample);
         v = ((64'(diff) * 64'(slope_down[chan])) >> scm_pkg::GAIN_FRAC) + 64'(cfg_low_base);
      end
      if (v > 64'hFFFF) v = 64'hFFFF;
      if (stick && v < 64'(cfg_dead_high) && v > 64'(cfg_dead_low))
         v = 64'(cfg_center);
      res.value = v[15:0];
      res.chan = chan;
      return 1'b1;
   endfunction

   task automatic send_item(input logic [scm_pkg::MODE_BITS-1:0] mode, input logic [2:0] chan,
                            input logic [scm_pkg::SAMPLE_BITS-1:0] sample, input bit fixed,
                            input logic [15:0] want);
      map_result_type res;
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= scm_pkg::REQ_TDATA_BITS'({sample, chan});
      req_tuser <= mode;
      do @(posedge clock); while (!req_tready);
      if (map_item(mode, chan, sample, res)) begin
         if (fixed) res.value = want;
         mapped_values.push_back(res);
      end
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mapped_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings();
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= scm_pkg::CSR_INDEX_BITS'(i);
         csr_wdata <= next_cfg[i];
         @(posedge clock);
         case (scm_pkg::CSR_INDEX_BITS'(i))
            scm_pkg::CSR_STROKE: cfg_stroke = next_cfg[i][scm_pkg::STROKE_BITS-1:0];
            scm_pkg::CSR_LOW_BASE: cfg_low_base = next_cfg[i];
            scm_pkg::CSR_MID_BASE: cfg_mid_base = next_cfg[i];
            scm_pkg::CSR_DEAD_LOW: cfg_dead_low = next_cfg[i];
            scm_pkg::CSR_DEAD_HIGH: cfg_dead_high = next_cfg[i];
            scm_pkg::CSR_CENTER_VALUE: cfg_center = next_cfg[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [scm_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return scm_pkg::SAMPLE_BITS'(2040 + $urandom_range(0, 16));
         default: return scm_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
      endcase
   endfunction

   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mapped_values.size() == 0) begin
            report_mismatch("result with nothing pending, value", int'(rsp_tdata[15:0]), 0);
         end else begin
            want = mapped_values.pop_front();
            if (rsp_tdata[15:0] !== want.value)
               report_mismatch("value", int'(rsp_tdata[15:0]), int'(want.value));
            if (rsp_tdata[18:16] !== want.chan)
               report_mismatch("out_channel", int'(rsp_tdata[18:16]), int'(want.chan));
            if (rsp_tuser[0] !== want.kind)
               report_mismatch("kind", int'(rsp_tuser[0]), int'(want.kind));
         end
      end
   end

   initial begin
      int counted, n, r, c;
      logic [scm_pkg::MODE_BITS-1:0] m;
      logic [2:0] ch;
      bit ignored;

      cfg_stroke = scm_pkg::STROKE_RESET;
      cfg_low_base = scm_pkg::LOW_BASE_RESET;
      cfg_mid_base = scm_pkg::MID_BASE_RESET;
      cfg_dead_low = scm_pkg::DEAD_LOW_RESET;
      cfg_dead_high = scm_pkg::DEAD_HIGH_RESET;
      cfg_center = scm_pkg::CENTER_VALUE_RESET;
      for (int i = 0; i < scm_pkg::NUM_CHANNELS; i++) begin
         cal_min[i] = scm_pkg::RANGE_RESET;
         cal_max[i] = scm_pkg::RANGE_RESET;
         cal_mid[i] = '0;
         slope_up[i] = scm_pkg::GAIN_HIGH_RESET;
         slope_down[i] = '0;
      end
      bat_avg = scm_pkg::BAT_RESET;

      directed_rows = '{
         '{scm_pkg::MODE_BATTERY,   3'd0, 12'd0,    1'b1, 16'd3780},
         '{scm_pkg::MODE_CONVERT,   3'd0, 12'd0,    1'b1, 16'd1500},
         '{scm_pkg::MODE_CONVERT,   3'd5, 12'd4095, 1'b1, 16'd2499},
         '{scm_pkg::MODE_BATTERY,   3'd7, 12'd4095, 1'b0, 16'd0},
         '{MODE_SPARE_A,            3'd0, 12'd0,    1'b0, 16'd0},
         '{MODE_SPARE_B,            3'd5, 12'd4095, 1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd6, 12'd100,  1'b0, 16'd0},
         '{scm_pkg::MODE_TRACK,     3'd7, 12'd4095, 1'b0, 16'd0},
         '{scm_pkg::MODE_RESET_CAL, 3'd3, 12'd1234, 1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd2, 12'd0,    1'b1, 16'd5096},
         '{scm_pkg::MODE_CONVERT,   3'd2, 12'd4095, 1'b1, 16'd4595},
         '{scm_pkg::MODE_TRACK,     3'd0, 12'd4095, 1'b0, 16'd0},
         '{scm_pkg::MODE_TRACK,     3'd0, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_CAPTURE,   3'd0, 12'd2048, 1'b0, 16'd0},
         '{scm_pkg::MODE_GAINS,     3'd0, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd0, 12'd4095, 1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd0, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd0, 12'd2048, 1'b0, 16'd0},
         '{scm_pkg::MODE_CAPTURE,   3'd1, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_TRACK,     3'd1, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_GAINS,     3'd1, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd1, 12'd4095, 1'b0, 16'd0},
         '{scm_pkg::MODE_TRACK,     3'd4, 12'd77,   1'b0, 16'd0},
         '{scm_pkg::MODE_CAPTURE,   3'd4, 12'd3000, 1'b0, 16'd0},
         '{scm_pkg::MODE_GAINS,     3'd4, 12'd0,    1'b0, 16'd0},
         '{scm_pkg::MODE_CONVERT,   3'd4, 12'd2046, 1'b0, 16'd0},
         '{scm_pkg::MODE_CAPTURE,   3'd7, 12'd5,    1'b0, 16'd0},
         '{scm_pkg::MODE_GAINS,     3'd6, 12'd0,    1'b0, 16'd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].chan, directed_rows[i].sample,
                   directed_rows[i].fixed, directed_rows[i].want);

      for (int p = 0; p < 5; p++) begin
         drain_block();
         if (p == 0) begin
            next_cfg[scm_pkg::CSR_STROKE] = 16'd1;
            next_cfg[scm_pkg::CSR_LOW_BASE] = '0;
            next_cfg[scm_pkg::CSR_MID_BASE] = '0;
            next_cfg[scm_pkg::CSR_DEAD_LOW] = '0;
            next_cfg[scm_pkg::CSR_DEAD_HIGH] = '0;
            next_cfg[scm_pkg::CSR_CENTER_VALUE] = '0;
         end else if (p == 1) begin
            next_cfg[scm_pkg::CSR_STROKE] = 16'd4095;
            next_cfg[scm_pkg::CSR_LOW_BASE] = '1;
            next_cfg[scm_pkg::CSR_MID_BASE] = '1;
            next_cfg[scm_pkg::CSR_DEAD_LOW] = '1;
            next_cfg[scm_pkg::CSR_DEAD_HIGH] = '1;
            next_cfg[scm_pkg::CSR_CENTER_VALUE] = '1;
         end else if ($urandom_range(0, 1)) begin
            next_cfg[scm_pkg::CSR_STROKE] = 16'($urandom_range(1, 4095));
            next_cfg[scm_pkg::CSR_LOW_BASE] = 16'($urandom_range(0, 65535));
            next_cfg[scm_pkg::CSR_MID_BASE] = 16'($urandom_range(0, 65535));
            next_cfg[scm_pkg::CSR_DEAD_LOW] = 16'($urandom_range(0, 65535));
            next_cfg[scm_pkg::CSR_DEAD_HIGH] = 16'($urandom_range(0, 65535));
            next_cfg[scm_pkg::CSR_CENTER_VALUE] = 16'($urandom_range(0, 65535));
         end else begin
            // deadband hugging the middle output
            next_cfg[scm_pkg::CSR_STROKE] = 16'($urandom_range(50, 1000));
            next_cfg[scm_pkg::CSR_LOW_BASE] = 16'($urandom_range(100, 2000));
            next_cfg[scm_pkg::CSR_MID_BASE] =
               next_cfg[scm_pkg::CSR_LOW_BASE] + 16'($urandom_range(0, 2000));
            next_cfg[scm_pkg::CSR_DEAD_LOW] =
               next_cfg[scm_pkg::CSR_MID_BASE] - 16'($urandom_range(1, 60));
            next_cfg[scm_pkg::CSR_DEAD_HIGH] =
               next_cfg[scm_pkg::CSR_MID_BASE] + 16'($urandom_range(1, 60));
            next_cfg[scm_pkg::CSR_CENTER_VALUE] = next_cfg[scm_pkg::CSR_MID_BASE];
         end
         program_settings();
         steady = (p == 2);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 25) begin
               // calibration run on one channel followed by conversions
               c = $urandom_range(0, scm_pkg::NUM_CHANNELS - 1);
               if ($urandom_range(0, 5) == 0) begin
                  send_item(scm_pkg::MODE_RESET_CAL, 3'($urandom_range(0, 7)), pick_sample(),
                            1'b0, '0);
                  counted++;
               end
               n = $urandom_range(2, 6);
               repeat (n) send_item(scm_pkg::MODE_TRACK, 3'(c), pick_sample(), 1'b0, '0);
               send_item(scm_pkg::MODE_CAPTURE, 3'(c), pick_sample(), 1'b0, '0);
               send_item(scm_pkg::MODE_GAINS, 3'(c), pick_sample(), 1'b0, '0);
               counted += n + 2;
               n = $urandom_range(3, 8);
               repeat (n) send_item(scm_pkg::MODE_CONVERT, 3'(c), pick_sample(), 1'b0, '0);
               counted += n;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 45) m = scm_pkg::MODE_CONVERT;
               else if (r < 60) m = scm_pkg::MODE_TRACK;
               else if (r < 68) m = scm_pkg::MODE_CAPTURE;
               else if (r < 78) m = scm_pkg::MODE_GAINS;
               else if (r < 90) m = scm_pkg::MODE_BATTERY;
               else if (r < 93) m = scm_pkg::MODE_RESET_CAL;
               else m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
               ch = 3'($urandom_range(0, 7));
               send_item(m, ch, pick_sample(), 1'b0, '0);
               ignored = (m > scm_pkg::MODE_BATTERY) ||
                         (ch >= scm_pkg::NUM_CHANNELS && m != scm_pkg::MODE_RESET_CAL &&
                          m != scm_pkg::MODE_BATTERY);
               if (!ignored) counted++;
            end
         end
         steady = 1'b0;
      end

      drain_block();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
